// File: design/cci_pkg.sv
// Shared types and constants for the circle-circle intersection pipeline.
// No dependencies; used by circle_circle_intersection.
package cci_pkg;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_COIN = 2'd2;

    // iteration counts of the bit-serial units, one stage per result bit
    localparam int SQ1_N = 33;   // floor sqrt of the squared centre distance
    localparam int DV1_N = 32;   // foot length quotient
    localparam int SQ2_N = 31;   // floor sqrt of the height squared
    localparam int DV2_N = 34;   // offset quotients

    // geometry that travels with a request
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [32:0]        adx;
        logic [32:0]        ady;
        logic               dxn;
        logic               dyn;
        logic               dyp;
        logic [30:0]        ra;
    } geo_t;

    typedef struct packed {
        geo_t        g;
        logic [61:0] ra2;
        logic [65:0] kmag;
        logic        kneg;
        logic        coin;
    } p1_t;

    typedef struct packed {
        geo_t        g;
        logic [61:0] ra2;
        logic        kneg;
        logic        coin;
        logic [32:0] d;
        logic        ovf;
    } p2_t;

    typedef struct packed {
        geo_t        g;
        logic        kneg;
        logic [1:0]  st;
        logic [32:0] d;
        logic [30:0] lm;
    } p3_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [1:0]         st;
        logic [32:0]        d;
        logic               nx;
        logic               ny;
        logic               ovfx;
        logic               ovfy;
    } p4_t;

endpackage

// File: design/circle_circle_intersection.sv
// Circle-circle intersection, left-hand point, as a fully pipelined datapath.
// Depends on cci_pkg (types, status codes, iteration counts).
//
// Channel   Dir  Handshake           Payload
// --------  ---  ------------------  -----------------------------------------------
// s_*       in   s_tvalid/s_tready   tdata: a_x, a_y, b_x, b_y, r_a, r_b
// m_*       out  m_tvalid/m_tready   tdata: point_x, point_y; tuser: status
//
// One request enters every cycle while the output is not stalled; the pipeline depth is set by the four bit-serial
// units (sqrt of the squared distance, foot division, height sqrt, offset division)
// that each spend one register stage per result bit.
// Reset clears only the valid bits; payload registers carry no reset.
// A stall at the output freezes every stage together, so nothing is dropped or repeated.
module circle_circle_intersection
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] center_a_x, [63:32] center_a_y, [95:64] center_b_x,
    // [127:96] center_b_y, [158:128] radius_a, [189:159] radius_b, [191:190] zero
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] point_x, [63:32] point_y
    output logic [63:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser
);

    localparam int S1 = cci_pkg::SQ1_N;
    localparam int D1 = cci_pkg::DV1_N;
    localparam int S2 = cci_pkg::SQ2_N;
    localparam int D2 = cci_pkg::DV2_N;

    typedef struct packed {
        logic [64:0] mag;
        logic        neg;
    } smag_t;

    // signed-magnitude sum of two magnitudes with sign flags
    function automatic smag_t ssum(logic [63:0] m1, logic s1, logic [63:0] m2, logic s2);
        smag_t r;
        if (s1 == s2)
        begin
            r.mag = 65'(m1) + 65'(m2);
            r.neg = s1;
        end
        else if (m1 >= m2)
        begin
            r.mag = 65'(m1 - m2);
            r.neg = s1;
        end
        else
        begin
            r.mag = 65'(m2 - m1);
            r.neg = s2;
        end
        return r;
    endfunction

    // clamp a 37-bit signed coordinate to 32 bits
    function automatic logic [31:0] sat32(logic [36:0] v);
        logic [31:0] r;
        if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111))
            r = v[31:0];
        else if (v[36])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    // the whole pipe moves together whenever the output register can take a result
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage A: centre differences ----------------
    logic               a_vld_reg;
    logic signed [31:0] a_ax_reg, a_ay_reg;
    logic [32:0]        a_dx_reg, a_dy_reg;
    logic [30:0]        a_ra_reg, a_rb_reg;
    logic [32:0]        a_dx_next, a_dy_next;

    assign a_dx_next = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
    assign a_dy_next = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};

    // ---------------- stage B: magnitudes and signs ----------------
    logic               b_vld_reg;
    cci_pkg::geo_t      b_geo_reg, b_geo_next;
    logic [30:0]        b_rb_reg;

    always_comb
    begin
        b_geo_next.ax  = a_ax_reg;
        b_geo_next.ay  = a_ay_reg;
        b_geo_next.adx = a_dx_reg[32] ? 33'(-a_dx_reg) : a_dx_reg;
        b_geo_next.ady = a_dy_reg[32] ? 33'(-a_dy_reg) : a_dy_reg;
        b_geo_next.dxn = a_dx_reg[32];
        b_geo_next.dyn = a_dy_reg[32];
        b_geo_next.dyp = !a_dy_reg[32] && (a_dy_reg != 33'd0);
        b_geo_next.ra  = a_ra_reg;
    end

    // ---------------- stage C: squares ----------------
    logic               c_vld_reg;
    cci_pkg::geo_t      c_geo_reg;
    logic [64:0]        c_adx2_reg, c_ady2_reg;
    logic [61:0]        c_ra2_reg, c_rb2_reg;

    // ---------------- stage D: squared distance ----------------
    logic               d_vld_reg;
    cci_pkg::geo_t      d_geo_reg;
    logic [65:0]        d_d2_reg;
    logic [61:0]        d_ra2_reg, d_rb2_reg;

    // ---------------- stage E: ra^2 + d^2 ----------------
    logic               e_vld_reg;
    cci_pkg::geo_t      e_geo_reg;
    logic [65:0]        e_d2_reg, e_p_reg;
    logic [61:0]        e_ra2_reg, e_rb2_reg;

    // ---------------- sqrt unit 1: d = floor(sqrt(d2)) ----------------
    logic [S1:0]        r1_vld_reg;
    logic [65:0]        r1_x_reg    [S1+1];
    logic [33:0]        r1_rem_reg  [S1+1];
    logic [32:0]        r1_root_reg [S1+1];
    cci_pkg::p1_t       r1_ctx_reg  [S1+1];
    logic [65:0]        r1_x_next    [S1+1];
    logic [33:0]        r1_rem_next  [S1+1];
    logic [32:0]        r1_root_next [S1+1];
    cci_pkg::p1_t       r1_ctx_next  [S1+1];

    always_comb
    begin
        logic [35:0] sh;
        logic [35:0] tr;
        r1_x_next[0]         = e_d2_reg;
        r1_rem_next[0]       = '0;
        r1_root_next[0]      = '0;
        r1_ctx_next[0].g     = e_geo_reg;
        r1_ctx_next[0].ra2   = e_ra2_reg;
        r1_ctx_next[0].kneg  = e_p_reg < 66'(e_rb2_reg);
        r1_ctx_next[0].kmag  = (e_p_reg < 66'(e_rb2_reg)) ? 66'(e_rb2_reg) - e_p_reg
                                                            : e_p_reg - 66'(e_rb2_reg);
        r1_ctx_next[0].coin  = e_d2_reg == 66'd0;
        for (int i = 1; i <= S1; i++)
        begin
            sh = {r1_rem_reg[i-1], r1_x_reg[i-1][65:64]};
            tr = {1'b0, r1_root_reg[i-1], 2'b01};
            if (sh >= tr)
            begin
                r1_rem_next[i]  = 34'(sh - tr);
                r1_root_next[i] = {r1_root_reg[i-1][31:0], 1'b1};
            end
            else
            begin
                r1_rem_next[i]  = sh[33:0];
                r1_root_next[i] = {r1_root_reg[i-1][31:0], 1'b0};
            end
            r1_x_next[i]   = r1_x_reg[i-1] << 2;
            r1_ctx_next[i] = r1_ctx_reg[i-1];
        end
    end

    // ---------------- stage G: numerator of the foot length ----------------
    logic               g_vld_reg;
    cci_pkg::p2_t       g_ctx_reg, g_ctx_next;
    logic [66:0]        g_num_reg, g_num_next;

    always_comb
    begin
        g_ctx_next.g    = r1_ctx_reg[S1].g;
        g_ctx_next.ra2  = r1_ctx_reg[S1].ra2;
        g_ctx_next.kneg = r1_ctx_reg[S1].kneg;
        g_ctx_next.coin = r1_ctx_reg[S1].coin;
        g_ctx_next.d    = r1_root_reg[S1];
        g_ctx_next.ovf  = 1'b0;
        g_num_next      = 67'(r1_ctx_reg[S1].kmag) + 67'(r1_root_reg[S1]);
    end

    // ---------------- divider 1: l = (|K| + d) div 2d ----------------
    logic [D1:0]        v_vld_reg;
    logic [33:0]        v_rem_reg  [D1+1];
    logic [31:0]        v_low_reg  [D1+1];
    logic [31:0]        v_quo_reg  [D1+1];
    cci_pkg::p2_t       v_ctx_reg  [D1+1];
    logic [33:0]        v_rem_next [D1+1];
    logic [31:0]        v_low_next [D1+1];
    logic [31:0]        v_quo_next [D1+1];
    cci_pkg::p2_t       v_ctx_next [D1+1];

    always_comb
    begin
        logic [34:0] sh;
        logic [34:0] dv;
        v_rem_next[0]     = g_num_reg[65:32];
        v_low_next[0]     = g_num_reg[31:0];
        v_quo_next[0]     = '0;
        v_ctx_next[0]     = g_ctx_reg;
        // a quotient that does not fit 32 bits is far beyond any radius
        v_ctx_next[0].ovf = g_num_reg[66:32] >= {1'b0, g_ctx_reg.d, 1'b0};
        for (int i = 1; i <= D1; i++)
        begin
            sh = {v_rem_reg[i-1], v_low_reg[i-1][31]};
            dv = {1'b0, v_ctx_reg[i-1].d, 1'b0};
            if (sh >= dv)
            begin
                v_rem_next[i] = 34'(sh - dv);
                v_quo_next[i] = {v_quo_reg[i-1][30:0], 1'b1};
            end
            else
            begin
                v_rem_next[i] = sh[33:0];
                v_quo_next[i] = {v_quo_reg[i-1][30:0], 1'b0};
            end
            v_low_next[i] = v_low_reg[i-1] << 1;
            v_ctx_next[i] = v_ctx_reg[i-1];
        end
    end

    // ---------------- stage I: status and l^2 ----------------
    logic               i_vld_reg;
    cci_pkg::p3_t       i_ctx_reg, i_ctx_next;
    logic [61:0]        i_ra2_reg, i_lsq_reg, i_lsq_next;

    always_comb
    begin
        logic [31:0] lm;
        lm              = v_quo_reg[D1];
        i_ctx_next.g    = v_ctx_reg[D1].g;
        i_ctx_next.kneg = v_ctx_reg[D1].kneg;
        i_ctx_next.d    = v_ctx_reg[D1].d;
        i_ctx_next.lm   = lm[30:0];
        if (v_ctx_reg[D1].coin)
            i_ctx_next.st = cci_pkg::ST_COIN;
        else if (v_ctx_reg[D1].ovf || (lm > 32'(v_ctx_reg[D1].g.ra)))
            i_ctx_next.st = cci_pkg::ST_MISS;
        else
            i_ctx_next.st = cci_pkg::ST_OK;
        i_lsq_next = 62'(lm[30:0]) * 62'(lm[30:0]);
    end

    // ---------------- sqrt unit 2: h = floor(sqrt(ra^2 - l^2)) ----------------
    logic [S2:0]        r2_vld_reg;
    logic [61:0]        r2_x_reg    [S2+1];
    logic [31:0]        r2_rem_reg  [S2+1];
    logic [30:0]        r2_root_reg [S2+1];
    cci_pkg::p3_t       r2_ctx_reg  [S2+1];
    logic [61:0]        r2_x_next    [S2+1];
    logic [31:0]        r2_rem_next  [S2+1];
    logic [30:0]        r2_root_next [S2+1];
    cci_pkg::p3_t       r2_ctx_next  [S2+1];

    always_comb
    begin
        logic [33:0] sh;
        logic [33:0] tr;
        r2_x_next[0]    = i_ra2_reg - i_lsq_reg;
        r2_rem_next[0]  = '0;
        r2_root_next[0] = '0;
        r2_ctx_next[0]  = i_ctx_reg;
        for (int i = 1; i <= S2; i++)
        begin
            sh = {r2_rem_reg[i-1], r2_x_reg[i-1][61:60]};
            tr = {1'b0, r2_root_reg[i-1], 2'b01};
            if (sh >= tr)
            begin
                r2_rem_next[i]  = 32'(sh - tr);
                r2_root_next[i] = {r2_root_reg[i-1][29:0], 1'b1};
            end
            else
            begin
                r2_rem_next[i]  = sh[31:0];
                r2_root_next[i] = {r2_root_reg[i-1][29:0], 1'b0};
            end
            r2_x_next[i]   = r2_x_reg[i-1] << 2;
            r2_ctx_next[i] = r2_ctx_reg[i-1];
        end
    end

    // ---------------- stage K: the four cross products ----------------
    logic               k_vld_reg;
    cci_pkg::p4_t       k_ctx_reg, k_ctx_next;
    logic [63:0]        k_pxl_reg, k_pyh_reg, k_pyl_reg, k_pxh_reg;
    logic               k_s1x_reg, k_s2x_reg, k_s1y_reg, k_s2y_reg;

    always_comb
    begin
        k_ctx_next.ax   = r2_ctx_reg[S2].g.ax;
        k_ctx_next.ay   = r2_ctx_reg[S2].g.ay;
        k_ctx_next.st   = r2_ctx_reg[S2].st;
        k_ctx_next.d    = r2_ctx_reg[S2].d;
        k_ctx_next.nx   = 1'b0;
        k_ctx_next.ny   = 1'b0;
        k_ctx_next.ovfx = 1'b0;
        k_ctx_next.ovfy = 1'b0;
    end

    // ---------------- stage L: signed-magnitude sums ----------------
    logic               l_vld_reg;
    cci_pkg::p4_t       l_ctx_reg;
    smag_t              l_mx_reg, l_my_reg;

    // ---------------- stage M: add d/2 for rounding ----------------
    logic               m_vld_reg;
    cci_pkg::p4_t       m_ctx_reg, m_ctx_next;
    logic [65:0]        m_numx_reg, m_numy_reg;

    always_comb
    begin
        m_ctx_next    = l_ctx_reg;
        m_ctx_next.nx = l_mx_reg.neg;
        m_ctx_next.ny = l_my_reg.neg;
    end

    // ---------------- divider pair 2: offsets = num div d ----------------
    logic [D2:0]        w_vld_reg;
    logic [32:0]        w_remx_reg  [D2+1];
    logic [32:0]        w_remy_reg  [D2+1];
    logic [33:0]        w_lowx_reg  [D2+1];
    logic [33:0]        w_lowy_reg  [D2+1];
    logic [33:0]        w_quox_reg  [D2+1];
    logic [33:0]        w_quoy_reg  [D2+1];
    cci_pkg::p4_t       w_ctx_reg   [D2+1];
    logic [32:0]        w_remx_next [D2+1];
    logic [32:0]        w_remy_next [D2+1];
    logic [33:0]        w_lowx_next [D2+1];
    logic [33:0]        w_lowy_next [D2+1];
    logic [33:0]        w_quox_next [D2+1];
    logic [33:0]        w_quoy_next [D2+1];
    cci_pkg::p4_t       w_ctx_next  [D2+1];

    always_comb
    begin
        logic [33:0] shx;
        logic [33:0] shy;
        logic [33:0] dv;
        w_remx_next[0]      = 33'(m_numx_reg[65:34]);
        w_remy_next[0]      = 33'(m_numy_reg[65:34]);
        w_lowx_next[0]      = m_numx_reg[33:0];
        w_lowy_next[0]      = m_numy_reg[33:0];
        w_quox_next[0]      = '0;
        w_quoy_next[0]      = '0;
        w_ctx_next[0]       = m_ctx_reg;
        // offsets that overflow 34 bits saturate the coordinate anyway
        w_ctx_next[0].ovfx  = 33'(m_numx_reg[65:34]) >= m_ctx_reg.d;
        w_ctx_next[0].ovfy  = 33'(m_numy_reg[65:34]) >= m_ctx_reg.d;
        for (int i = 1; i <= D2; i++)
        begin
            dv  = {1'b0, w_ctx_reg[i-1].d};
            shx = {w_remx_reg[i-1], w_lowx_reg[i-1][33]};
            shy = {w_remy_reg[i-1], w_lowy_reg[i-1][33]};
            if (shx >= dv)
            begin
                w_remx_next[i] = 33'(shx - dv);
                w_quox_next[i] = {w_quox_reg[i-1][32:0], 1'b1};
            end
            else
            begin
                w_remx_next[i] = shx[32:0];
                w_quox_next[i] = {w_quox_reg[i-1][32:0], 1'b0};
            end
            if (shy >= dv)
            begin
                w_remy_next[i] = 33'(shy - dv);
                w_quoy_next[i] = {w_quoy_reg[i-1][32:0], 1'b1};
            end
            else
            begin
                w_remy_next[i] = shy[32:0];
                w_quoy_next[i] = {w_quoy_reg[i-1][32:0], 1'b0};
            end
            w_lowx_next[i] = w_lowx_reg[i-1] << 1;
            w_lowy_next[i] = w_lowy_reg[i-1] << 1;
            w_ctx_next[i]  = w_ctx_reg[i-1];
        end
    end

    // ---------------- stage O: add offsets to centre A ----------------
    logic               o_vld_reg;
    logic [1:0]         o_st_reg;
    logic [36:0]        o_vx_reg, o_vy_reg, o_vx_next, o_vy_next;

    always_comb
    begin
        logic [36:0] offx;
        logic [36:0] offy;
        logic [36:0] bx;
        logic [36:0] by;
        offx = w_ctx_reg[D2].ovfx ? (37'd1 << D2) : 37'(w_quox_reg[D2]);
        offy = w_ctx_reg[D2].ovfy ? (37'd1 << D2) : 37'(w_quoy_reg[D2]);
        bx   = {{5{w_ctx_reg[D2].ax[31]}}, w_ctx_reg[D2].ax};
        by   = {{5{w_ctx_reg[D2].ay[31]}}, w_ctx_reg[D2].ay};
        o_vx_next = w_ctx_reg[D2].nx ? bx - offx : bx + offx;
        o_vy_next = w_ctx_reg[D2].ny ? by - offy : by + offy;
    end

    // ---------------- output register ----------------
    logic               out_vld_reg;
    logic [31:0]        out_x_reg, out_y_reg;
    logic [1:0]         out_st_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_st_reg;

    // valid bits: the only registers under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            r1_vld_reg  <= '0;
            g_vld_reg   <= 1'b0;
            v_vld_reg   <= '0;
            i_vld_reg   <= 1'b0;
            r2_vld_reg  <= '0;
            k_vld_reg   <= 1'b0;
            l_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            w_vld_reg   <= '0;
            o_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= s_tvalid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            r1_vld_reg  <= {r1_vld_reg[S1-1:0], e_vld_reg};
            g_vld_reg   <= r1_vld_reg[S1];
            v_vld_reg   <= {v_vld_reg[D1-1:0], g_vld_reg};
            i_vld_reg   <= v_vld_reg[D1];
            r2_vld_reg  <= {r2_vld_reg[S2-1:0], i_vld_reg};
            k_vld_reg   <= r2_vld_reg[S2];
            l_vld_reg   <= k_vld_reg;
            m_vld_reg   <= l_vld_reg;
            w_vld_reg   <= {w_vld_reg[D2-1:0], m_vld_reg};
            o_vld_reg   <= w_vld_reg[D2];
            out_vld_reg <= o_vld_reg;
        end
    end

    // datapath: advance every stage together, hold on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ax_reg   <= s_tdata[31:0];
            a_ay_reg   <= s_tdata[63:32];
            a_dx_reg   <= a_dx_next;
            a_dy_reg   <= a_dy_next;
            a_ra_reg   <= s_tdata[158:128];
            a_rb_reg   <= s_tdata[189:159];

            b_geo_reg  <= b_geo_next;
            b_rb_reg   <= a_rb_reg;

            c_geo_reg  <= b_geo_reg;
            c_adx2_reg <= 65'(b_geo_reg.adx) * 65'(b_geo_reg.adx);
            c_ady2_reg <= 65'(b_geo_reg.ady) * 65'(b_geo_reg.ady);
            c_ra2_reg  <= 62'(b_geo_reg.ra) * 62'(b_geo_reg.ra);
            c_rb2_reg  <= 62'(b_rb_reg) * 62'(b_rb_reg);

            d_geo_reg  <= c_geo_reg;
            d_d2_reg   <= 66'(c_adx2_reg) + 66'(c_ady2_reg);
            d_ra2_reg  <= c_ra2_reg;
            d_rb2_reg  <= c_rb2_reg;

            e_geo_reg  <= d_geo_reg;
            e_d2_reg   <= d_d2_reg;
            e_p_reg    <= d_d2_reg + 66'(d_ra2_reg);
            e_ra2_reg  <= d_ra2_reg;
            e_rb2_reg  <= d_rb2_reg;

            for (int i = 0; i <= S1; i++)
            begin
                r1_x_reg[i]    <= r1_x_next[i];
                r1_rem_reg[i]  <= r1_rem_next[i];
                r1_root_reg[i] <= r1_root_next[i];
                r1_ctx_reg[i]  <= r1_ctx_next[i];
            end

            g_ctx_reg  <= g_ctx_next;
            g_num_reg  <= g_num_next;

            for (int i = 0; i <= D1; i++)
            begin
                v_rem_reg[i] <= v_rem_next[i];
                v_low_reg[i] <= v_low_next[i];
                v_quo_reg[i] <= v_quo_next[i];
                v_ctx_reg[i] <= v_ctx_next[i];
            end

            i_ctx_reg  <= i_ctx_next;
            i_ra2_reg  <= v_ctx_reg[D1].ra2;
            i_lsq_reg  <= i_lsq_next;

            for (int i = 0; i <= S2; i++)
            begin
                r2_x_reg[i]    <= r2_x_next[i];
                r2_rem_reg[i]  <= r2_rem_next[i];
                r2_root_reg[i] <= r2_root_next[i];
                r2_ctx_reg[i]  <= r2_ctx_next[i];
            end

            k_ctx_reg  <= k_ctx_next;
            k_pxl_reg  <= 64'(r2_ctx_reg[S2].g.adx) * 64'(r2_ctx_reg[S2].lm);
            k_pyh_reg  <= 64'(r2_ctx_reg[S2].g.ady) * 64'(r2_root_reg[S2]);
            k_pyl_reg  <= 64'(r2_ctx_reg[S2].g.ady) * 64'(r2_ctx_reg[S2].lm);
            k_pxh_reg  <= 64'(r2_ctx_reg[S2].g.adx) * 64'(r2_root_reg[S2]);
            k_s1x_reg  <= r2_ctx_reg[S2].g.dxn ^ r2_ctx_reg[S2].kneg;
            k_s2x_reg  <= r2_ctx_reg[S2].g.dyp;
            k_s1y_reg  <= r2_ctx_reg[S2].g.dyn ^ r2_ctx_reg[S2].kneg;
            k_s2y_reg  <= r2_ctx_reg[S2].g.dxn;

            l_ctx_reg  <= k_ctx_reg;
            l_mx_reg   <= ssum(k_pxl_reg, k_s1x_reg, k_pyh_reg, k_s2x_reg);
            l_my_reg   <= ssum(k_pyl_reg, k_s1y_reg, k_pxh_reg, k_s2y_reg);

            m_ctx_reg     <= m_ctx_next;
            m_numx_reg    <= 66'(l_mx_reg.mag) + 66'(l_ctx_reg.d[32:1]);
            m_numy_reg    <= 66'(l_my_reg.mag) + 66'(l_ctx_reg.d[32:1]);

            for (int i = 0; i <= D2; i++)
            begin
                w_remx_reg[i] <= w_remx_next[i];
                w_remy_reg[i] <= w_remy_next[i];
                w_lowx_reg[i] <= w_lowx_next[i];
                w_lowy_reg[i] <= w_lowy_next[i];
                w_quox_reg[i] <= w_quox_next[i];
                w_quoy_reg[i] <= w_quoy_next[i];
                w_ctx_reg[i]  <= w_ctx_next[i];
            end

            o_st_reg   <= w_ctx_reg[D2].st;
            o_vx_reg   <= o_vx_next;
            o_vy_reg   <= o_vy_next;

            // drop the point for failed requests
            out_st_reg <= o_st_reg;
            out_x_reg  <= (o_st_reg == cci_pkg::ST_OK) ? sat32(o_vx_reg) : 32'd0;
            out_y_reg  <= (o_st_reg == cci_pkg::ST_OK) ? sat32(o_vy_reg) : 32'd0;
        end
    end

endmodule

// File: verif/tb.sv
// Testbench for circle_circle_intersection: a short table of geometry requests, then random
// circle pairs that mostly intersect, checked against typed points or a bit-exact predictor.
// Depends on cci_pkg (status codes) and the circle_circle_intersection RTL.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [1:0]         st;
    } point_t;

    typedef struct {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        ra;
        logic [30:0]        rb;
        bit                 typed;   // expected point is written in the row
        point_t             pt;
    } geo_row_t;

    localparam int N_RAND = 700;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    point_t   pending_points[$];
    int       err_count = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    geo_row_t dir_rows[$];

    circle_circle_intersection uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // floor square root, operand below 2^80
    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 40; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // signed-magnitude add; neg gets the sign of the sum
    function automatic logic [127:0] sm_add(input logic [127:0] m1, input bit s1,
                                            input logic [127:0] m2, input bit s2,
                                            output bit neg);
        if (s1 == s2)
        begin
            neg = s1;
            return m1 + m2;
        end
        if (m1 >= m2)
        begin
            neg = s1;
            return m1 - m2;
        end
        neg = s2;
        return m2 - m1;
    endfunction

    // round the offset to nearest, clamp it, add to the base and saturate to 32 bits
    function automatic logic signed [31:0] place_coord(input logic signed [31:0] base,
                                                       input logic [127:0] mag, input bit neg,
                                                       input logic [127:0] d);
        logic [127:0] q;
        longint       v;
        q = (mag + (d >> 1)) / d;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        v = longint'(base) + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic point_t left_intersection(input geo_row_t g);
        point_t       res;
        longint       dx;
        longint       dy;
        logic [127:0] adx, ady, d2, d, p, q, kmag, lv, ra_w, rb_w, h, mx, my;
        bit           kneg, nx, ny;
        res = '{px: 0, py: 0, st: cci_pkg::ST_OK};
        dx = longint'(g.bx) - longint'(g.ax);
        dy = longint'(g.by) - longint'(g.ay);
        adx = dx < 0 ? 128'(-dx) : 128'(dx);
        ady = dy < 0 ? 128'(-dy) : 128'(dy);
        ra_w = 128'(g.ra);
        rb_w = 128'(g.rb);
        d2 = adx * adx + ady * ady;
        if (d2 == 0)
        begin
            res.st = cci_pkg::ST_COIN;
            return res;
        end
        d = floor_sqrt(d2);
        p = ra_w * ra_w + d2;
        q = rb_w * rb_w;
        kneg = p < q;
        kmag = kneg ? q - p : p - q;
        lv = (kmag + d) / (2 * d);
        if (lv > ra_w)
        begin
            res.st = cci_pkg::ST_MISS;
            return res;
        end
        h = floor_sqrt(ra_w * ra_w - lv * lv);
        mx = sm_add(adx * lv, (dx < 0) != kneg, ady * h, dy > 0, nx);
        my = sm_add(ady * lv, (dy < 0) != kneg, adx * h, dx < 0, ny);
        res.px = place_coord(g.ax, mx, nx, d);
        res.py = place_coord(g.ay, my, ny, d);
        return res;
    endfunction

    function automatic geo_row_t mk_row(input longint ax, ay, bx, by, ra, rb);
        geo_row_t r;
        r.ax = ax[31:0];
        r.ay = ay[31:0];
        r.bx = bx[31:0];
        r.by = by[31:0];
        r.ra = ra[30:0];
        r.rb = rb[30:0];
        r.typed = 1'b0;
        r.pt = '0;
        return r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // mostly a pair of circles that meet, at a random scale; now and then raw noise
    function automatic geo_row_t random_geometry();
        longint ax, ay, dx, dy, ra, rb, lo, hi;
        real    span;
        int     sc;
        if ($urandom_range(99) < 20)
            return mk_row(longint'($signed($urandom)), longint'($signed($urandom)),
                          longint'($signed($urandom)), longint'($signed($urandom)),
                          longint'($urandom), longint'($urandom));
        sc = $urandom_range(29, 2);
        ax = longint'($signed($urandom));
        ay = longint'($signed($urandom));
        dx = longint'($urandom_range((1 << sc) - 1)) - (longint'(1) << (sc - 1));
        dy = longint'($urandom_range((1 << sc) - 1)) - (longint'(1) << (sc - 1));
        dx = clamp32(ax + dx) - ax;
        dy = clamp32(ay + dy) - ay;
        span = $sqrt(real'(dx) * real'(dx) + real'(dy) * real'(dy));
        ra = longint'($urandom_range(1 << sc));
        lo = longint'(span) - ra;
        if (lo < 0)
            lo = -lo;
        hi = longint'(span) + ra;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        if (lo > hi)
            lo = hi;
        rb = lo + longint'($urandom_range(32'(hi - lo)));
        return mk_row(ax, ay, ax + dx, ay + dy, ra, rb);
    endfunction

    // drive one request, holding it until the block takes it; queue what it must yield
    task automatic send_geometry(input geo_row_t g);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, g.rb, g.ra, g.by, g.bx, g.ay, g.ax};
        do
            @(posedge clk);
        while (!s_tready);
        pending_points.push_back(g.typed ? g.pt : left_intersection(g));
    endtask

    // check each delivered point against the oldest pending one; randomize backpressure
    always @(posedge clk)
    begin
        point_t got;
        point_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{px: m_tdata[31:0], py: m_tdata[63:32], st: m_tuser};
                if (pending_points.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result x=%0d y=%0d status=%0d",
                             $time, got.px, got.py, got.st);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.px !== want.px)
                    begin
                        err_count++;
                        $display("%0t: point_x expected %0d actual %0d", $time, want.px, got.px);
                    end
                    if (got.py !== want.py)
                    begin
                        err_count++;
                        $display("%0t: point_y expected %0d actual %0d", $time, want.py, got.py);
                    end
                    if (got.st !== want.st)
                    begin
                        err_count++;
                        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        geo_row_t r;
        int       wait_cycles;

        // coincident centres: no point, status only
        r = mk_row(0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.pt = '{px: 0, py: 0, st: cci_pkg::ST_COIN};
        dir_rows.push_back(r);
        r = mk_row(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                   64'sd2147483647, 64'sd2147483647);
        r.typed = 1'b1;
        r.pt = '{px: 0, py: 0, st: cci_pkg::ST_COIN};
        dir_rows.push_back(r);
        // circles too far apart
        r = mk_row(0, 0, 64'sd10 << 16, 0, 64'sd1 << 16, 64'sd1 << 16);
        r.typed = 1'b1;
        r.pt = '{px: 0, py: 0, st: cci_pkg::ST_MISS};
        dir_rows.push_back(r);
        // one circle inside the other
        r = mk_row(0, 0, 64'sd1 << 16, 0, 64'sd10 << 16, 64'sd1 << 16);
        r.typed = 1'b1;
        r.pt = '{px: 0, py: 0, st: cci_pkg::ST_MISS};
        dir_rows.push_back(r);
        // touching circles: the single point halfway between the centres
        r = mk_row(0, 0, 64'sd2 << 16, 0, 64'sd1 << 16, 64'sd1 << 16);
        r.typed = 1'b1;
        r.pt = '{px: 32'sd65536, py: 0, st: cci_pkg::ST_OK};
        dir_rows.push_back(r);
        // radius a zero (radius b zero, then one), unit distance
        dir_rows.push_back(mk_row(0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 1));
        // extreme corners and full-scale radii; saturation on both sides
        dir_rows.push_back(mk_row(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                                  64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
        dir_rows.push_back(mk_row(64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
                                  -64'sd2147483648, 64'sd2147483647, 64'sd2147483647));
        dir_rows.push_back(mk_row(64'sd2147483647, -64'sd2147483648, 64'sd2147483647 - 10,
                                  -64'sd2147483648, 64'sd2147483647, 64'sd2147483647));
        dir_rows.push_back(mk_row(-64'sd2147483648, 0, -64'sd2147483648, 100,
                                  64'sd2147483647, 64'sd2147483647 - 50));
        // all ones on every field
        dir_rows.push_back(mk_row(-1, -1, -1, -1, 64'sh7FFFFFFF, 64'sh7FFFFFFF));
        // unit circles with centre b above, left of and below centre a; then a 3-4-5 case
        dir_rows.push_back(mk_row(0, 0, 0, 64'sd1 << 16, 64'sd1 << 16, 64'sd1 << 16));
        dir_rows.push_back(mk_row(0, 0, -(64'sd1 << 16), 0, 64'sd1 << 16, 64'sd1 << 16));
        dir_rows.push_back(mk_row(0, 0, 0, -(64'sd1 << 16), 64'sd1 << 16, 64'sd1 << 16));
        dir_rows.push_back(mk_row(64'sd5 << 16, -(64'sd3 << 16), 64'sd8 << 16, 64'sd1 << 16,
                                  64'sd4 << 16, 64'sd3 << 16));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_geometry(dir_rows[i]);

        // phases: free flow, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1) ? 73 : (ph == 3) ? 37 : 0;
            sink_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 37 : 0;
            for (int n = 0; n < N_RAND / 4; n++)
                send_geometry(random_geometry());
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_points.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (err_count == 0 && pending_points.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
